### rtl/pal_pkg.sv
// Package for the positional array list: field widths, command and status codes,
// and the sequencer state type.
// It has no dependencies. Every other file in the project except pal_ram imports it.
package pal_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int LEN_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS,
        S_DEL,
        S_SRCH,
        S_RD,
        S_DONE
    } state_t;

endpackage

### rtl/pal_req_if.sv
// Request channel of the positional array list: valid, ready and the command fields.
// It depends on pal_pkg for the field widths.
interface pal_req_if import pal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output cmd, output position, output item_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input item_value,
                    output ready);
endinterface

### rtl/pal_rsp_if.sv
// Response channel of the positional array list: valid, ready and the result fields.
// It depends on pal_pkg for the field widths.
interface pal_rsp_if import pal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [FIDX_W-1:0]       found_index;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        list_length;

    modport source (output valid, output status, output found_index, output read_value,
                    output list_length, input ready);
    modport sink   (input valid, input status, input found_index, input read_value,
                    input list_length, output ready);
endinterface

### rtl/positional_array_list.sv
// Positional array list: an ordered list of signed 32-bit values held in one RAM.
// It depends on pal_pkg, pal_req_if, pal_rsp_if and pal_ram. Ready is high only while idle.
// After acceptance each command is decoded: clear, rejected and unknown commands finish there,
// read waits for the RAM, insert moves the entries from the position up one slot and writes the
// new one, delete moves those above it down, search scans from index 0 to the first hit. One entry per cycle.
// A finished result waits while the previous one is unaccepted. Reset empties the list at once.
module positional_array_list import pal_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = CW + POS_W;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [IW-1:0]           wa_reg, wa_next;
    logic                    pend_reg, pend_next;
    logic                    ov_reg, ov_next;

    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    status_t                 st_status_reg, st_status_next;
    logic [FIDX_W-1:0]       st_fidx_reg, st_fidx_next;
    logic [VAL_W-1:0]        st_rval_reg, st_rval_next;
    logic [STATUS_W-1:0]     o_status_reg, o_status_next;
    logic [FIDX_W-1:0]       o_fidx_reg, o_fidx_next;
    logic [VAL_W-1:0]        o_rval_reg, o_rval_next;
    logic [LEN_W-1:0]        o_len_reg, o_len_next;

    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [IW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    logic [CMPW-1:0]         pos_ext;
    logic [CMPW-1:0]         cnt_ext;
    logic [CMPW-1:0]         k_ext;
    logic [CW-1:0]           k_dec;
    logic [CW-1:0]           k_inc;
    logic [IW+FIDX_W-1:0]    fidx_wide;
    logic [CW+LEN_W-1:0]     len_wide;

    pal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_ext   = {{CW{1'b0}}, pos_reg};
    assign cnt_ext   = {{POS_W{1'b0}}, count_reg};
    assign k_ext     = {{POS_W{1'b0}}, k_reg};
    assign k_dec     = k_reg - CW'(1);
    assign k_inc     = k_reg + CW'(1);
    assign fidx_wide = {{FIDX_W{1'b0}}, wa_reg};
    assign len_wide  = {{LEN_W{1'b0}}, count_reg};

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = ov_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.found_index = o_fidx_reg;
    assign rsp.read_value  = o_rval_reg;
    assign rsp.list_length = o_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        wa_reg        <= wa_next;
        cmd_reg       <= cmd_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        st_status_reg <= st_status_next;
        st_fidx_reg   <= st_fidx_next;
        st_rval_reg   <= st_rval_next;
        o_status_reg  <= o_status_next;
        o_fidx_reg    <= o_fidx_next;
        o_rval_reg    <= o_rval_next;
        o_len_reg     <= o_len_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        wa_next        = wa_reg;
        pend_next      = pend_reg;
        ov_next        = ov_reg && !rsp.ready;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        st_status_next = st_status_reg;
        st_fidx_next   = st_fidx_reg;
        st_rval_next   = st_rval_reg;
        o_status_next  = o_status_reg;
        o_fidx_next    = o_fidx_reg;
        o_rval_next    = o_rval_reg;
        o_len_next     = o_len_reg;
        ram_we         = 1'b0;
        ram_waddr      = wa_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = k_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    pos_next   = req.position;
                    val_next   = req.item_value;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                st_status_next = ST_OK;
                st_fidx_next   = '0;
                st_rval_next   = '0;
                pend_next      = 1'b0;
                state_next     = S_DONE;
                unique case (cmd_t'(cmd_reg))
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    CMD_INSERT:
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            st_status_next = ST_BADPOS;
                        end
                        else if (count_reg == CW'(DEPTH))
                        begin
                            st_status_next = ST_FULL;
                        end
                        else
                        begin
                            k_next     = count_reg;
                            state_next = S_INS;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            st_status_next = ST_BADPOS;
                        end
                        else
                        begin
                            k_next     = pos_ext[CW-1:0];
                            state_next = S_DEL;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        k_next     = '0;
                        state_next = S_SRCH;
                    end
                    CMD_READ:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            st_status_next = ST_BADPOS;
                        end
                        else
                        begin
                            ram_raddr  = pos_ext[IW-1:0];
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        st_status_next = ST_OK;
                    end
                endcase
            end
            S_INS:
            begin
                // Entries move up from the top: read one below, write it one slot higher.
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    pend_next = 1'b0;
                end
                if (k_ext > pos_ext)
                begin
                    ram_raddr = k_dec[IW-1:0];
                    pend_next = 1'b1;
                    wa_next   = k_reg[IW-1:0];
                    k_next    = k_dec;
                end
                else if (!pend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_ext[IW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DEL:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    pend_next = 1'b0;
                end
                if (k_inc < count_reg)
                begin
                    ram_raddr = k_inc[IW-1:0];
                    pend_next = 1'b1;
                    wa_next   = k_reg[IW-1:0];
                    k_next    = k_inc;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (pend_reg && (ram_rdata == val_reg))
                begin
                    st_fidx_next = fidx_wide[FIDX_W-1:0];
                    pend_next    = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (k_reg < count_reg)
                    begin
                        pend_next = 1'b1;
                        wa_next   = k_reg[IW-1:0];
                        k_next    = k_inc;
                    end
                    else if (!pend_reg)
                    begin
                        st_status_next = ST_NOTFOUND;
                        state_next     = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                st_rval_next = ram_rdata;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next       = 1'b1;
                    o_status_next = st_status_reg;
                    o_fidx_next   = st_fidx_reg;
                    o_rval_next   = st_rval_reg;
                    o_len_next    = len_wide[LEN_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list length exceeds the store depth");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_DONE))
        else $error("result presented outside the completion step");

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_INS || state_reg == S_DEL || state_reg == S_SRCH))
        else $error("pending entry move outside a walk");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction did not start decoding");

    a_count_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_DONE))
        else $error("list length changed outside command completion");

endmodule

### rtl/pal_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### verif/positional_array_list_checker.sv
// Checker for the positional array list: keeps its own copy of the list, predicts each result
// from the accepted commands and compares the results field by field in order.
// It depends on pal_pkg, pal_req_if and pal_rsp_if.
module positional_array_list_checker import pal_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    pal_req_if   req,
    pal_rsp_if   rsp,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        status_t                 status;
        logic [FIDX_W-1:0]       found_index;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        list_length;
    } list_result_t;

    logic signed [VAL_W-1:0] slots [DEPTH];
    int                      fill_count;
    list_result_t            awaited_results [$];
    list_result_t            oldest;
    int                      fail_count = 0;

    assign errors = fail_count;

    function automatic list_result_t apply_command(logic [CMD_W-1:0] code,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [VAL_W-1:0] value);
        list_result_t r;
        int           k;
        bit           hit;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        case (code)
            CMD_CLEAR:
            begin
                fill_count = 0;
            end
            CMD_INSERT:
            begin
                if (int'(pos) > fill_count)
                begin
                    r.status = ST_BADPOS;
                end
                else if (fill_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (k = fill_count; k > int'(pos); k--)
                    begin
                        slots[k] = slots[k-1];
                    end
                    slots[pos] = value;
                    fill_count++;
                end
            end
            CMD_DELETE:
            begin
                if (int'(pos) >= fill_count)
                begin
                    r.status = ST_BADPOS;
                end
                else
                begin
                    for (k = int'(pos); k + 1 < fill_count; k++)
                    begin
                        slots[k] = slots[k+1];
                    end
                    fill_count--;
                end
            end
            CMD_SEARCH:
            begin
                r.status = ST_NOTFOUND;
                for (k = 0; k < fill_count && !hit; k++)
                begin
                    if (slots[k] == value)
                    begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.found_index = k[FIDX_W-1:0];
                    end
                end
            end
            CMD_READ:
            begin
                if (int'(pos) >= fill_count)
                begin
                    r.status = ST_BADPOS;
                end
                else
                begin
                    r.read_value = slots[pos];
                end
            end
            default:
            begin
            end
        endcase
        r.list_length = fill_count[LEN_W-1:0];
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count = 0;
            awaited_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result transaction with no command outstanding", $time);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    check_field("status", oldest.status, rsp.status);
                    check_field("found_index", oldest.found_index, rsp.found_index);
                    check_field("read_value", oldest.read_value, rsp.read_value);
                    check_field("list_length", oldest.list_length, rsp.list_length);
                end
            end
            if (req.valid && req.ready)
            begin
                awaited_results.push_back(apply_command(req.cmd, req.position, req.item_value));
            end
        end
        pending = awaited_results.size();
    end

endmodule

### verif/positional_array_list_test.sv
// Top of the positional array list testbench: clock, reset, command stimulus with random
// gaps and result stalls, and the final verdict.
// It depends on pal_pkg, both channel interfaces, the block and positional_array_list_checker.
module positional_array_list_test;
    import pal_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int ITEM_TARGET = 1900;

    logic clk;
    logic rst_n;
    int   error_count;
    int   pending_count;
    int   sent_count = 0;
    int   shadow_len = 0;
    bit   calm_tx = 1'b0;
    bit   calm_rx = 1'b0;
    logic signed [VAL_W-1:0] value_pool [6];

    pal_req_if req_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list #(.DEPTH(LIST_DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    positional_array_list_checker #(.DEPTH(LIST_DEPTH)) list_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (error_count),
        .pending (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
        begin
            return value_pool[$urandom_range(0, 5)];
        end
        return $urandom;
    endfunction

    task automatic send_command(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] value);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 59) == 0)
        begin
            calm_tx = !calm_tx;
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= code;
        req_ch.position   <= pos;
        req_ch.item_value <= value;
        do @(posedge clk); while (!req_ch.ready);
        sent_count++;
        case (code)
            CMD_CLEAR:
            begin
                shadow_len = 0;
            end
            CMD_INSERT:
            begin
                if (int'(pos) <= shadow_len && shadow_len < LIST_DEPTH)
                begin
                    shadow_len++;
                end
            end
            CMD_DELETE:
            begin
                if (int'(pos) < shadow_len)
                begin
                    shadow_len--;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic fill_list();
        send_command(CMD_CLEAR, POS_W'($urandom), $urandom);
        while (shadow_len < LIST_DEPTH)
        begin
            send_command(CMD_INSERT, POS_W'($urandom_range(0, shadow_len)), pick_value());
        end
        send_command(CMD_INSERT, POS_W'(LIST_DEPTH), pick_value());
        send_command(CMD_INSERT, POS_W'(LIST_DEPTH + 1), pick_value());
        send_command(CMD_INSERT, POS_W'($urandom_range(0, LIST_DEPTH - 1)), pick_value());
        send_command(CMD_SEARCH, 0, pick_value());
        send_command(CMD_READ, POS_W'(LIST_DEPTH - 1), 0);
        send_command(CMD_DELETE, POS_W'($urandom_range(0, LIST_DEPTH - 1)), 0);
    endtask

    task automatic mixed_commands(int n);
        int               sel;
        logic [CMD_W-1:0] code;
        logic [POS_W-1:0] pos;
        repeat (n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 3)
            begin
                code = CMD_CLEAR;
            end
            else if (sel < 7)
            begin
                code = CMD_W'($urandom_range(5, 7));
            end
            else if (sel < 47)
            begin
                code = CMD_INSERT;
            end
            else if (sel < 67)
            begin
                code = CMD_DELETE;
            end
            else if (sel < 84)
            begin
                code = CMD_SEARCH;
            end
            else
            begin
                code = CMD_READ;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                pos = POS_W'($urandom_range(0, 31));
            end
            else if (code == CMD_INSERT)
            begin
                pos = POS_W'($urandom_range(0, shadow_len));
            end
            else if (shadow_len > 0)
            begin
                pos = POS_W'($urandom_range(0, shadow_len - 1));
            end
            else
            begin
                pos = 0;
            end
            send_command(code, pos, pick_value());
        end
    endtask

    initial
    begin
        int stall;
        int taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken == 150 || taken == 1100)
            begin
                stall = 400;
            end
            else
            begin
                stall = calm_rx ? 0 : $urandom_range(0, 13);
            end
            if ($urandom_range(0, 59) == 0)
            begin
                calm_rx = !calm_rx;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    initial
    begin
        value_pool[0] = 0;
        value_pool[1] = -1;
        value_pool[2] = 32'sh8000_0000;
        value_pool[3] = 32'sh7fff_ffff;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_CLEAR;
        req_ch.position   <= '0;
        req_ch.item_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_CLEAR, 0, 0);
        send_command(CMD_READ, 0, 0);
        send_command(CMD_DELETE, 0, 0);
        send_command(CMD_SEARCH, 0, 0);
        send_command(CMD_INSERT, 1, 5);
        send_command(CMD_INSERT, 0, 32'sh7fff_ffff);
        send_command(CMD_INSERT, 0, 32'sh8000_0000);
        send_command(CMD_INSERT, 2, -1);
        send_command(CMD_INSERT, 1, 0);
        send_command(CMD_SEARCH, 0, -1);
        send_command(CMD_SEARCH, 0, 12345);
        send_command(CMD_READ, 3, 0);
        send_command(CMD_READ, 31, 0);
        send_command(CMD_DELETE, 1, 0);
        send_command(CMD_DELETE, 31, 0);
        send_command(3'd5, 31, -1);
        send_command(3'd6, 0, 0);
        send_command(3'd7, 16, 32'sh5555_aaaa);
        send_command(CMD_SEARCH, 0, 32'sh8000_0000);

        while (sent_count < ITEM_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                fill_list();
            end
            else
            begin
                mixed_commands($urandom_range(20, 60));
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
